// ===== src/i2cm_pkg.sv =====
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam logic [2:0] FUNC_NONE    = 3'd0;
  localparam logic [2:0] FUNC_PROBE   = 3'd1;
  localparam logic [2:0] FUNC_WRITE   = 3'd2;
  localparam logic [2:0] FUNC_READ    = 3'd3;
  localparam logic [2:0] FUNC_RECOVER = 3'd4;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_ADDR_NACK = 3'd1;
  localparam logic [2:0] STS_REG_NACK  = 3'd2;
  localparam logic [2:0] STS_DATA_NACK = 3'd3;
  localparam logic [2:0] STS_RADR_NACK = 3'd4;
  localparam logic [2:0] STS_BAD_LEN   = 3'd5;
  localparam logic [2:0] STS_STUCK     = 3'd6;

  typedef struct packed {
    logic       cmd_go;
    logic       bad_len;
    logic [2:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [8:0] length;
    logic [7:0] wr_data;
    logic       wr_valid;
    logic       sda_in;
    logic       scl_in;
  } tick_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       wr_request;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       done_res;
    logic [2:0] status;
  } result_t;

endpackage

// ===== src/i2cm_front.sv =====
`timescale 1ns / 1ps
module i2cm_front #(
  parameter int MAX_LENGTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [2:0]     in_func,
  input  logic [6:0]     in_dev_addr,
  input  logic [7:0]     in_reg_addr,
  input  logic [8:0]     in_length,
  input  logic [7:0]     in_wr_data,
  input  logic           in_wr_valid,
  input  logic           in_sda_in,
  input  logic           in_scl_in,
  output logic           q_valid,
  output i2cm_pkg::tick_t q_item,
  input  logic           q_pop
);
  import i2cm_pkg::*;

  tick_t      slot_r [2];
  tick_t      item;
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       is_xfer;

  // Classify the request before it enters the queue.
  always_comb begin
    is_xfer       = (in_func == FUNC_WRITE) || (in_func == FUNC_READ);
    item.func     = in_func;
    item.cmd_go   = (in_func == FUNC_PROBE) || (in_func == FUNC_WRITE) ||
                    (in_func == FUNC_READ) || (in_func == FUNC_RECOVER);
    item.bad_len  = is_xfer && ((in_length == 9'd0) ||
                    (32'(in_length) > 32'(MAX_LENGTH)));
    item.dev_addr = in_dev_addr;
    item.reg_addr = in_reg_addr;
    item.length   = in_length;
    item.wr_data  = in_wr_data;
    item.wr_valid = in_wr_valid;
    item.sda_in   = in_sda_in;
    item.scl_in   = in_scl_in;
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== src/i2cm_engine.sv =====
`timescale 1ns / 1ps
module i2cm_engine #(
  parameter int RECOVERY_PULSES = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  i2cm_pkg::tick_t   item,
  input  logic [15:0]       phase_ticks,
  output i2cm_pkg::result_t res
);
  import i2cm_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_START1 = 5'd1;
  localparam logic [4:0] ST_SADDR  = 5'd2;
  localparam logic [4:0] ST_AADDR  = 5'd3;
  localparam logic [4:0] ST_SREG   = 5'd4;
  localparam logic [4:0] ST_AREG   = 5'd5;
  localparam logic [4:0] ST_WAITD  = 5'd6;
  localparam logic [4:0] ST_SDATA  = 5'd7;
  localparam logic [4:0] ST_ADATA  = 5'd8;
  localparam logic [4:0] ST_START2 = 5'd9;
  localparam logic [4:0] ST_SADDRR = 5'd10;
  localparam logic [4:0] ST_AADDRR = 5'd11;
  localparam logic [4:0] ST_RBIT   = 5'd12;
  localparam logic [4:0] ST_RACK   = 5'd13;
  localparam logic [4:0] ST_STOP   = 5'd14;
  localparam logic [4:0] ST_RCHK   = 5'd15;
  localparam logic [4:0] ST_RPULSE = 5'd16;

  logic [4:0]  stage_r, stage_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [8:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [6:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [3:0]  pulse_r, pulse_nxt;
  logic [15:0] ticks;
  logic [1:0]  slot_cnt;
  logic        is_send, is_ack, nack;

  always_comb begin
    stage_nxt = stage_r;  slot_nxt = slot_r;  timer_nxt = timer_r;
    bit_nxt   = bit_r;    byte_nxt = byte_r;  shift_nxt = shift_r;
    dev_nxt   = dev_r;    reg_nxt  = reg_r;   len_nxt   = len_r;
    cmd_nxt   = cmd_r;    pulse_nxt = pulse_r;
    res       = '0;
    ticks     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    slot_cnt  = 2'd3;
    is_send   = 1'b0;
    is_ack    = 1'b0;
    nack      = 1'b0;

    if (stage_r == ST_IDLE && item.cmd_go) begin
      if (item.bad_len) begin
        res.done_res = 1'b1;
        res.status   = STS_BAD_LEN;
      end else begin
        cmd_nxt   = item.func;
        dev_nxt   = item.dev_addr;
        reg_nxt   = item.reg_addr;
        len_nxt   = item.length;
        bit_nxt   = 4'd0;
        byte_nxt  = 9'd0;
        pulse_nxt = 4'd0;
        shift_nxt = 8'd0;
        stage_nxt = (item.func == FUNC_RECOVER) ? ST_RCHK : ST_START1;
        slot_nxt  = 2'd0;
        timer_nxt = 16'd0;
      end
    end

    if (stage_nxt != ST_IDLE) begin
      is_send = (stage_nxt == ST_SADDR) || (stage_nxt == ST_SREG) ||
                (stage_nxt == ST_SDATA) || (stage_nxt == ST_SADDRR);
      is_ack  = (stage_nxt == ST_AADDR) || (stage_nxt == ST_AREG) ||
                (stage_nxt == ST_ADATA) || (stage_nxt == ST_AADDRR);
      if (stage_nxt == ST_RCHK) slot_cnt = 2'd1;
      else if (stage_nxt == ST_RPULSE) slot_cnt = 2'd2;

      // Pin levels come from the slot that runs on this tick.
      if (stage_nxt == ST_START1 || stage_nxt == ST_START2) begin
        res.sda_pull_low = (slot_nxt >= 2'd1);
        res.scl_pull_low = (slot_nxt == 2'd2);
      end else if (stage_nxt == ST_STOP) begin
        res.sda_pull_low = (slot_nxt <= 2'd1);
        res.scl_pull_low = (slot_nxt == 2'd0);
      end else if (stage_nxt == ST_RCHK) begin
        res.scl_pull_low = 1'b0;
      end else if (stage_nxt == ST_RPULSE) begin
        res.scl_pull_low = (slot_nxt == 2'd0);
      end else if (stage_nxt == ST_WAITD) begin
        res.scl_pull_low = 1'b1;
      end else begin
        res.scl_pull_low = (slot_nxt != 2'd1);
        if (is_send) res.sda_pull_low = !shift_nxt[7];
        else if (stage_nxt == ST_RACK)
          res.sda_pull_low = ({1'b0, byte_nxt} + 10'd1) < {1'b0, len_nxt};
      end

      if (stage_nxt == ST_WAITD) begin
        res.wr_request = 1'b1;
        if (item.wr_valid) begin
          shift_nxt = item.wr_data;
          bit_nxt   = 4'd0;
          stage_nxt = ST_SDATA;
          slot_nxt  = 2'd0;
          timer_nxt = 16'd0;
        end
      end else if (({1'b0, timer_nxt} + 17'd1) < {1'b0, ticks}) begin
        timer_nxt = timer_nxt + 16'd1;
      end else begin
        timer_nxt = 16'd0;
        if (slot_nxt == 2'd1 && is_ack) bit_nxt = {3'd0, item.sda_in};
        if (slot_nxt == 2'd1 && stage_nxt == ST_RBIT)
          shift_nxt = {shift_nxt[6:0], item.sda_in};
        if ((slot_nxt + 2'd1) < slot_cnt) begin
          slot_nxt = slot_nxt + 2'd1;
        end else if (is_send) begin
          shift_nxt = {shift_nxt[6:0], 1'b0};
          bit_nxt   = bit_nxt + 4'd1;
          slot_nxt  = 2'd0;
          if (bit_nxt >= 4'd8) begin
            bit_nxt   = 4'd0;
            stage_nxt = stage_nxt + 5'd1;
          end
        end else if (is_ack) begin
          nack     = (bit_nxt != 4'd0);
          bit_nxt  = 4'd0;
          slot_nxt = 2'd0;
          if (stage_nxt == ST_AADDR) begin
            if (nack) begin
              shift_nxt = {5'd0, STS_ADDR_NACK};
              stage_nxt = ST_STOP;
            end else if (cmd_nxt == FUNC_PROBE) begin
              shift_nxt = {5'd0, STS_OK};
              stage_nxt = ST_STOP;
            end else begin
              shift_nxt = reg_nxt;
              stage_nxt = ST_SREG;
            end
          end else if (stage_nxt == ST_AREG) begin
            if (nack) begin
              shift_nxt = {5'd0, STS_REG_NACK};
              stage_nxt = ST_STOP;
            end else if (cmd_nxt == FUNC_WRITE) begin
              byte_nxt  = 9'd0;
              stage_nxt = ST_WAITD;
            end else begin
              stage_nxt = ST_START2;
            end
          end else if (stage_nxt == ST_ADATA) begin
            if (nack) begin
              shift_nxt = {5'd0, STS_DATA_NACK};
              stage_nxt = ST_STOP;
            end else begin
              byte_nxt = byte_nxt + 9'd1;
              if (byte_nxt >= len_nxt) begin
                shift_nxt = {5'd0, STS_OK};
                stage_nxt = ST_STOP;
              end else begin
                stage_nxt = ST_WAITD;
              end
            end
          end else begin
            if (nack) begin
              shift_nxt = {5'd0, STS_RADR_NACK};
              stage_nxt = ST_STOP;
            end else begin
              byte_nxt  = 9'd0;
              shift_nxt = 8'd0;
              stage_nxt = ST_RBIT;
            end
          end
        end else begin
          slot_nxt = 2'd0;
          case (stage_nxt)
            ST_START1: begin
              shift_nxt = {dev_nxt, 1'b0};
              bit_nxt   = 4'd0;
              stage_nxt = ST_SADDR;
            end
            ST_START2: begin
              shift_nxt = {dev_nxt, 1'b1};
              bit_nxt   = 4'd0;
              stage_nxt = ST_SADDRR;
            end
            ST_RBIT: begin
              bit_nxt = bit_nxt + 4'd1;
              if (bit_nxt >= 4'd8) begin
                bit_nxt      = 4'd0;
                res.rd_valid = 1'b1;
                res.rd_data  = shift_nxt;
                stage_nxt    = ST_RACK;
              end
            end
            ST_RACK: begin
              byte_nxt = byte_nxt + 9'd1;
              if (byte_nxt >= len_nxt) begin
                shift_nxt = {5'd0, STS_OK};
                stage_nxt = ST_STOP;
              end else begin
                shift_nxt = 8'd0;
                bit_nxt   = 4'd0;
                stage_nxt = ST_RBIT;
              end
            end
            ST_STOP: begin
              res.done_res = 1'b1;
              if (cmd_nxt == FUNC_RECOVER)
                res.status = (item.sda_in && item.scl_in) ? STS_OK : STS_STUCK;
              else
                res.status = shift_nxt[2:0];
              stage_nxt = ST_IDLE;
            end
            ST_RCHK: begin
              if (item.sda_in) begin
                res.done_res = 1'b1;
                res.status   = STS_OK;
                stage_nxt    = ST_IDLE;
              end else begin
                pulse_nxt = 4'd0;
                stage_nxt = ST_RPULSE;
              end
            end
            ST_RPULSE: begin
              pulse_nxt = pulse_nxt + 4'd1;
              if (item.sda_in || (pulse_nxt >= 4'(RECOVERY_PULSES))) begin
                shift_nxt = {5'd0, STS_OK};
                stage_nxt = ST_STOP;
              end
            end
            default: begin
              stage_nxt = ST_IDLE;
            end
          endcase
        end
      end
    end
    res.busy_res = (stage_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_IDLE;
      slot_r  <= 2'd0;
      timer_r <= 16'd0;
      bit_r   <= 4'd0;
      byte_r  <= 9'd0;
      shift_r <= 8'd0;
      dev_r   <= 7'd0;
      reg_r   <= 8'd0;
      len_r   <= 9'd0;
      cmd_r   <= 3'd0;
      pulse_r <= 4'd0;
    end else if (step) begin
      stage_r <= stage_nxt;
      slot_r  <= slot_nxt;
      timer_r <= timer_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      dev_r   <= dev_nxt;
      reg_r   <= reg_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      pulse_r <= pulse_nxt;
    end
  end

endmodule

// ===== src/i2c_master_register_access.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// in_       request    in_valid/in_stall  func, addresses, length, write byte, line levels
// out_      result     out_valid/out_stall pin pulls, busy, request, read byte, done, status
// cfg_      write      cfg_we             phase_ticks
//
// One tick request yields one result; a new request is taken every cycle unless a stalled output fills the queue.
// A request is held in the two-entry queue, and the bus sequencer steps
// on it as it is popped; its result is registered in res_r and offered from there.
// Synchronous reset returns the sequencer to idle and phase_ticks to 100.
// A stalled output holds its result; the queue then fills and raises in_stall.
module i2c_master_register_access #(
  parameter int MAX_LENGTH      = 256,
  parameter int RECOVERY_PULSES = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [6:0]  in_dev_addr,
  input  logic [7:0]  in_reg_addr,
  input  logic [8:0]  in_length,
  input  logic [7:0]  in_wr_data,
  input  logic        in_wr_valid,
  input  logic        in_sda_in,
  input  logic        in_scl_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_pull_low,
  output logic        out_sda_pull_low,
  output logic        out_busy_res,
  output logic        out_wr_request,
  output logic        out_rd_valid,
  output logic [7:0]  out_rd_data,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  logic        q_valid, q_pop;
  tick_t       q_item;
  result_t     res, res_r;
  logic        out_valid_r;
  logic [15:0] phase_r;

  i2cm_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_dev_addr(in_dev_addr), .in_reg_addr(in_reg_addr),
    .in_length(in_length), .in_wr_data(in_wr_data), .in_wr_valid(in_wr_valid),
    .in_sda_in(in_sda_in), .in_scl_in(in_scl_in),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  i2cm_engine #(.RECOVERY_PULSES(RECOVERY_PULSES)) u_engine (
    .clk(clk), .rst_n(rst_n), .step(q_pop), .item(q_item),
    .phase_ticks(phase_r), .res(res)
  );

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 16'd100;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) phase_r <= cfg_data;
      if (q_pop) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_scl_pull_low = res_r.scl_pull_low;
  assign out_sda_pull_low = res_r.sda_pull_low;
  assign out_busy_res     = res_r.busy_res;
  assign out_wr_request   = res_r.wr_request;
  assign out_rd_valid     = res_r.rd_valid;
  assign out_rd_data      = res_r.rd_data;
  assign out_done_res     = res_r.done_res;
  assign out_status       = res_r.status;

endmodule

// ===== test/tb_i2c_master_register_access.sv =====
`timescale 1ns / 1ps
module tb_i2c_master_register_access;
  import i2cm_pkg::*;

  localparam int MAX_LEN = 256;
  localparam int RECOVERY_PULSES = 9;

  typedef enum logic [4:0] {
    S_IDLE = 5'd0, S_START1 = 5'd1, S_SADDR = 5'd2, S_AADDR = 5'd3, S_SREG = 5'd4,
    S_AREG = 5'd5, S_WAITD = 5'd6, S_SDATA = 5'd7, S_ADATA = 5'd8, S_START2 = 5'd9,
    S_SADDRR = 5'd10, S_AADDRR = 5'd11, S_RBIT = 5'd12, S_RACK = 5'd13, S_STOP = 5'd14,
    S_RCHK = 5'd15, S_RPULSE = 5'd16
  } stage_e;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [8:0] length;
    logic [7:0] wr_data;
    logic       wr_valid;
    logic       sda_in;
    logic       scl_in;
  } tick_req_t;

  class bus_sequencer_scoreboard;
    logic [15:0] phase_ticks;
    stage_e      stage;
    int unsigned slot, timer, bit_idx, byte_idx, pulses;
    logic [7:0]  shreg;
    logic [6:0]  dev;
    logic [7:0]  regad;
    logic [8:0]  len;
    logic [2:0]  cmd;
    result_t     pending[$];
    int          errors;

    function void clear();
      phase_ticks = 16'd100;
      stage = S_IDLE;
      slot = 0; timer = 0; bit_idx = 0; byte_idx = 0; pulses = 0;
      shreg = '0; dev = '0; regad = '0; len = '0; cmd = FUNC_NONE;
      errors = 0;
    endfunction

    function void enter(stage_e s);
      stage = s;
      slot = 0;
      timer = 0;
    endfunction

    function void go_stop(logic [2:0] code);
      shreg = {5'd0, code};
      enter(S_STOP);
    endfunction

    function void start_send(stage_e s, logic [7:0] b);
      shreg = b;
      bit_idx = 0;
      enter(s);
    endfunction

    function bit is_send(stage_e s);
      return s == S_SADDR || s == S_SREG || s == S_SDATA || s == S_SADDRR;
    endfunction

    function bit is_ack(stage_e s);
      return s == S_AADDR || s == S_AREG || s == S_ADATA || s == S_AADDRR;
    endfunction

    function void note_request(tick_req_t r);
      result_t     e;
      stage_e      st;
      int unsigned sl, ticks, nslots;
      bit          nack;
      e = '0;
      if (stage == S_IDLE && r.func >= FUNC_PROBE && r.func <= FUNC_RECOVER) begin
        if ((r.func == FUNC_WRITE || r.func == FUNC_READ) &&
            (r.length == 0 || r.length > MAX_LEN)) begin
          e.done_res = 1'b1;
          e.status = STS_BAD_LEN;
        end else begin
          cmd = r.func; dev = r.dev_addr; regad = r.reg_addr; len = r.length;
          bit_idx = 0; byte_idx = 0; pulses = 0; shreg = '0;
          enter(r.func == FUNC_RECOVER ? S_RCHK : S_START1);
        end
      end
      st = stage;
      sl = slot;
      if (st != S_IDLE) begin
        ticks = (phase_ticks == 0) ? 1 : phase_ticks;
        nslots = (st == S_RCHK) ? 1 : (st == S_RPULSE) ? 2 : 3;
        case (st)
          S_START1, S_START2: begin
            e.sda_pull_low = sl >= 1;
            e.scl_pull_low = sl == 2;
          end
          S_STOP: begin
            e.sda_pull_low = sl <= 1;
            e.scl_pull_low = sl == 0;
          end
          S_RCHK: ;
          S_RPULSE: e.scl_pull_low = sl == 0;
          S_WAITD: e.scl_pull_low = 1'b1;
          default: begin
            e.scl_pull_low = sl != 1;
            if (is_send(st)) e.sda_pull_low = !shreg[7];
            else if (st == S_RACK) e.sda_pull_low = (byte_idx + 1) < len;
          end
        endcase

        if (st == S_WAITD) begin
          e.wr_request = 1'b1;
          if (r.wr_valid) start_send(S_SDATA, r.wr_data);
        end else if (timer + 1 < ticks) begin
          timer++;
        end else begin
          timer = 0;
          if (sl == 1 && is_ack(st)) bit_idx = r.sda_in;
          if (sl == 1 && st == S_RBIT) shreg = {shreg[6:0], r.sda_in};
          if (sl + 1 < nslots) begin
            slot++;
          end else if (is_send(st)) begin
            shreg = shreg << 1;
            bit_idx++;
            if (bit_idx >= 8) begin
              bit_idx = 0;
              enter(stage_e'(st + 1));
            end else enter(st);
          end else if (is_ack(st)) begin
            nack = bit_idx != 0;
            bit_idx = 0;
            case (st)
              S_AADDR: begin
                if (nack) go_stop(STS_ADDR_NACK);
                else if (cmd == FUNC_PROBE) go_stop(STS_OK);
                else start_send(S_SREG, regad);
              end
              S_AREG: begin
                if (nack) go_stop(STS_REG_NACK);
                else if (cmd == FUNC_WRITE) begin
                  byte_idx = 0;
                  enter(S_WAITD);
                end else enter(S_START2);
              end
              S_ADATA: begin
                if (nack) go_stop(STS_DATA_NACK);
                else begin
                  byte_idx = (byte_idx + 1) & 9'h1FF;
                  if (byte_idx >= len) go_stop(STS_OK);
                  else enter(S_WAITD);
                end
              end
              default: begin
                if (nack) go_stop(STS_RADR_NACK);
                else begin
                  byte_idx = 0;
                  shreg = '0;
                  enter(S_RBIT);
                end
              end
            endcase
          end else begin
            case (st)
              S_START1: start_send(S_SADDR, {dev, 1'b0});
              S_START2: start_send(S_SADDRR, {dev, 1'b1});
              S_RBIT: begin
                bit_idx++;
                if (bit_idx >= 8) begin
                  bit_idx = 0;
                  e.rd_valid = 1'b1;
                  e.rd_data = shreg;
                  enter(S_RACK);
                end else enter(S_RBIT);
              end
              S_RACK: begin
                byte_idx = (byte_idx + 1) & 9'h1FF;
                if (byte_idx >= len) go_stop(STS_OK);
                else begin
                  shreg = '0;
                  bit_idx = 0;
                  enter(S_RBIT);
                end
              end
              S_STOP: begin
                e.done_res = 1'b1;
                if (cmd == FUNC_RECOVER) e.status = (r.sda_in && r.scl_in) ? STS_OK : STS_STUCK;
                else e.status = shreg[2:0];
                stage = S_IDLE;
                slot = 0;
              end
              S_RCHK: begin
                if (r.sda_in) begin
                  e.done_res = 1'b1;
                  e.status = STS_OK;
                  stage = S_IDLE;
                  slot = 0;
                end else begin
                  pulses = 0;
                  enter(S_RPULSE);
                end
              end
              S_RPULSE: begin
                pulses = (pulses + 1) & 4'hF;
                if (r.sda_in || pulses >= RECOVERY_PULSES) go_stop(STS_OK);
                else enter(S_RPULSE);
              end
              default: begin
                stage = S_IDLE;
                slot = 0;
              end
            endcase
          end
        end
      end
      e.busy_res = stage != S_IDLE;
      pending.push_back(e);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.scl_pull_low !== want.scl_pull_low || got.sda_pull_low !== want.sda_pull_low ||
          got.busy_res !== want.busy_res || got.wr_request !== want.wr_request ||
          got.rd_valid !== want.rd_valid || got.rd_data !== want.rd_data ||
          got.done_res !== want.done_res || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: expected scl %b sda %b busy %b req %b rdv %b rdd %h",
                   $time, want.scl_pull_low, want.sda_pull_low, want.busy_res,
                   want.wr_request, want.rd_valid, want.rd_data);
          $display("  expected done %b sts %0d, got scl %b sda %b busy %b req %b",
                   want.done_res, want.status, got.scl_pull_low, got.sda_pull_low,
                   got.busy_res, got.wr_request);
          $display("  got rdv %b rdd %h done %b sts %0d",
                   got.rd_valid, got.rd_data, got.done_res, got.status);
        end
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  tick_req_t   req;
  logic        out_valid, out_stall;
  result_t     res;
  logic        cfg_we;
  logic [15:0] cfg_data;
  bit          calm;
  int          item_count;

  bus_sequencer_scoreboard sb;

  i2c_master_register_access dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(req.func), .in_dev_addr(req.dev_addr), .in_reg_addr(req.reg_addr),
    .in_length(req.length), .in_wr_data(req.wr_data), .in_wr_valid(req.wr_valid),
    .in_sda_in(req.sda_in), .in_scl_in(req.scl_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_scl_pull_low(res.scl_pull_low), .out_sda_pull_low(res.sda_pull_low),
    .out_busy_res(res.busy_res), .out_wr_request(res.wr_request),
    .out_rd_valid(res.rd_valid), .out_rd_data(res.rd_data),
    .out_done_res(res.done_res), .out_status(res.status),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_i2c_master_register_access: errors");
    $finish;
  end

  // Stall pattern on the result side, with quiet stretches where nothing stalls.
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= !calm;
    if (!rst_n || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0) || ($urandom_range(0, 99) == 0 && out_stall);
    if (rst_n && out_valid && !out_stall) sb.check_result(res);
  end

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 7) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
  endfunction

  function automatic tick_req_t make_tick();
    tick_req_t r;
    int        k;
    r.dev_addr = 7'($urandom);
    r.reg_addr = 8'($urandom);
    r.wr_data  = 8'($urandom);
    k = $urandom_range(0, 19);
    if (k == 0) r.length = 9'd0;
    else if (k == 1) r.length = 9'($urandom_range(MAX_LEN + 1, 511));
    else r.length = 9'($urandom_range(1, 4));
    if (sb.stage == S_IDLE) begin
      k = $urandom_range(0, 15);
      if (k < 2) r.func = FUNC_NONE;
      else if (k == 2) r.func = 3'($urandom_range(5, 7));
      else if (k < 6) r.func = FUNC_PROBE;
      else if (k < 10) r.func = FUNC_WRITE;
      else if (k < 14) r.func = FUNC_READ;
      else r.func = FUNC_RECOVER;
    end else r.func = 3'($urandom_range(0, 7));
    r.wr_valid = (sb.stage == S_WAITD) ? ($urandom_range(0, 3) != 0) :
                 1'($urandom_range(0, 1));
    // Acks mostly come back low so that commands run to the data phase.
    if (sb.is_ack(sb.stage)) r.sda_in = $urandom_range(0, 11) == 0;
    else if (sb.stage == S_RPULSE) r.sda_in = $urandom_range(0, 4) == 0;
    else r.sda_in = 1'($urandom_range(0, 1));
    r.scl_in = $urandom_range(0, 7) != 0;
    return r;
  endfunction

  task automatic drive_tick(tick_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    item_count++;
  endtask

  task automatic run_command(logic [2:0] f, logic [6:0] d, logic [7:0] ra, logic [8:0] n);
    tick_req_t r;
    r = make_tick();
    r.func = f; r.dev_addr = d; r.reg_addr = ra; r.length = n;
    drive_tick(r);
    while (sb.stage != S_IDLE) drive_tick(make_tick());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_phase(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.phase_ticks = v;
  endtask

  task automatic random_phase(int n);
    int stop_at;
    stop_at = item_count + n;
    while (item_count < stop_at || sb.stage != S_IDLE) begin
      drive_tick(make_tick());
      if (item_count == stop_at - n / 2 && sb.stage == S_IDLE) drain();
    end
  endtask

  initial begin
    tick_req_t r;
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    req = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    item_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bad lengths and ignored functions at the reset timing.
    r = make_tick();
    r.func = FUNC_WRITE; r.length = 9'd0; drive_tick(r);
    r.func = FUNC_READ; r.length = 9'd257; drive_tick(r);
    r.func = FUNC_READ; r.length = 9'd511; drive_tick(r);
    r.func = FUNC_NONE; drive_tick(r);
    r.func = 3'd7; drive_tick(r);

    write_phase(16'd1);
    run_command(FUNC_PROBE, 7'h7F, 8'h00, 9'd1);
    run_command(FUNC_WRITE, 7'h00, 8'hFF, 9'd2);
    run_command(FUNC_READ, 7'h55, 8'hAA, 9'd1);
    run_command(FUNC_RECOVER, 7'h2A, 8'h11, 9'd3);
    run_command(FUNC_READ, 7'h00, 8'h00, 9'd2);

    random_phase(150);
    write_phase(16'd2);
    random_phase(120);
    write_phase(16'd0);
    random_phase(100);
    write_phase(16'd3);
    random_phase(60);
    // Slowest timing: only requests that never start bus activity.
    write_phase(16'hFFFF);
    r = make_tick();
    r.func = FUNC_READ; r.length = 9'd0; drive_tick(r);
    r.func = FUNC_NONE; drive_tick(r);
    r.func = FUNC_WRITE; r.length = 9'd300; drive_tick(r);

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("tb_i2c_master_register_access: clean");
    else $display("tb_i2c_master_register_access: errors");
    $finish;
  end

endmodule
